// ----- rtl/dfs_pkg.sv -----
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types, constants and helper functions of the drive failsafe
// supervisor: mode and stop codes, register indexes, fixed-point widths.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int IR_BITS_DEF   = 3;
    localparam int TIME_BITS_DEF = 48;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_SPEED     = 3'd0,
        CFG_MAX_TURN_RATE = 3'd1,
        CFG_DECEL_STEP    = 3'd2,
        CFG_WATCHDOG_MS   = 3'd3,
        CFG_ZERO_BAND     = 3'd4
    } cfg_index_t;

    // field widths
    localparam int SPEED_LIM_W = 12;
    localparam int TURN_LIM_W  = 13;
    localparam int STEP_W      = 16;
    localparam int BAND_W      = 16;
    localparam int WDOG_W      = 16;
    localparam int LIMIT_US_W  = 26;
    localparam int REQ_W       = 16;
    localparam int CMD_W       = 24;
    localparam int FRAC_BITS   = 8;
    localparam int AGE_MS_W    = 16;
    localparam int FAULT_W     = 5;
    localparam int SLEW_STEP_W = STEP_W + 4;

    // reset values of the registers
    localparam logic [SPEED_LIM_W-1:0] MAX_SPEED_RST  = SPEED_LIM_W'(1000);
    localparam logic [TURN_LIM_W-1:0]  MAX_TURN_RST   = TURN_LIM_W'(2000);
    localparam logic [STEP_W-1:0]      DECEL_STEP_RST = STEP_W'(256);
    localparam logic [WDOG_W-1:0]      WATCHDOG_RST   = WDOG_W'(200);
    localparam logic [BAND_W-1:0]      ZERO_BAND_RST  = BAND_W'(256);

    localparam int US_PER_MS = 1000;
    localparam logic [LIMIT_US_W-1:0] LIMIT_US_RST =
        LIMIT_US_W'(200 * US_PER_MS);

    // age in ms: saturate above the 16 bit range, otherwise
    // (age >> 3) / 125 by reciprocal multiply
    localparam longint AGE_SAT_US    = (64'd1 << AGE_MS_W) * US_PER_MS;
    localparam int     DIV_PRE_SHIFT = 3;
    localparam int     DIV_ODD       = US_PER_MS / (1 << DIV_PRE_SHIFT);
    localparam int     DIV_SHIFT     = 30;
    localparam longint DIV_MULT      = ((64'd1 << DIV_SHIFT) + DIV_ODD - 1) / DIV_ODD;
    localparam int     DIV_MULT_W    = 24;
    localparam int     DIV_IN_HI     = LIMIT_US_W - 1;
    localparam int     DIV_IN_W      = LIMIT_US_W - DIV_PRE_SHIFT;
    localparam int     PROD_W        = DIV_IN_W + DIV_MULT_W;

    // fault bit positions
    localparam int FLT_ESTOP  = 0;
    localparam int FLT_RANGE  = 1;
    localparam int FLT_LINK   = 2;
    localparam int FLT_IR     = 3;
    localparam int FLT_BUSOFF = 4;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_DEG  = 2'd2,
        MODE_SAFE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STOP_LINK   = 2'd0,
        STOP_IR     = 2'd1,
        STOP_BUSOFF = 2'd2
    } stop_code_t;

    typedef struct packed {
        logic [SPEED_LIM_W-1:0] max_speed;
        logic [TURN_LIM_W-1:0]  max_turn_rate;
        logic [STEP_W-1:0]      decel_step;
        logic [LIMIT_US_W-1:0]  limit_us;
        logic [BAND_W-1:0]      zero_band;
    } cfg_t;

    typedef struct packed {
        mode_t                    mode;
        logic [FAULT_W-1:0]       fault_flags;
        logic                     drive_enabled;
        logic signed [CMD_W-1:0]  speed_command;
        logic signed [CMD_W-1:0]  turn_command;
        logic                     stop_event;
        stop_code_t               stop_code;
        logic                     watchdog_miss;
    } result_t;

    function automatic logic [CMD_W:0] mag(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W:0] ext;
        ext = {v[CMD_W-1], v};
        return (ext < 0) ? $unsigned(-ext) : $unsigned(ext);
    endfunction

    // one slew step toward target, limited to +-step, then near-zero snap
    function automatic logic signed [CMD_W-1:0] slew(
        input logic signed [CMD_W-1:0]  val,
        input logic signed [CMD_W-1:0]  target,
        input logic [SLEW_STEP_W-1:0]   step,
        input logic [BAND_W-1:0]        band
    );
        logic signed [CMD_W:0]   lim;
        logic signed [CMD_W:0]   diff;
        logic signed [CMD_W:0]   nv;
        logic signed [CMD_W-1:0] res;
        lim  = $signed((CMD_W+1)'(step));
        diff = {target[CMD_W-1], target} - {val[CMD_W-1], val};
        if (diff > lim)
        begin
            diff = lim;
        end
        else if (diff < -lim)
        begin
            diff = -lim;
        end
        nv  = {val[CMD_W-1], val} + diff;
        res = nv[CMD_W-1:0];
        if (mag(res) < (CMD_W+1)'(band) && mag(target) < (CMD_W+1)'(band))
        begin
            res = '0;
        end
        return res;
    endfunction

endpackage

// ----- rtl/dfs_if.sv -----
// ----------------------------------------------------------------------------
// dfs_if
// Channel interfaces of the drive failsafe supervisor: tick items in,
// result items out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface dfs_in_if #(
    parameter int IR_BITS   = dfs_pkg::IR_BITS_DEF,
    parameter int TIME_BITS = dfs_pkg::TIME_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           setpoint_fresh;
    logic                           clear_request;
    logic                           estop_request;
    logic signed [dfs_pkg::REQ_W-1:0] speed_request;
    logic signed [dfs_pkg::REQ_W-1:0] turn_request;
    logic [TIME_BITS-1:0]           setpoint_rx_time;
    logic [TIME_BITS-1:0]           now_time;
    logic [IR_BITS-1:0]             ir_mask;
    logic                           bus_off;
    logic                           estop_line;

    modport source (
        output valid, setpoint_fresh, clear_request, estop_request, speed_request,
               turn_request, setpoint_rx_time, now_time, ir_mask, bus_off, estop_line,
        input  ready
    );
    modport sink (
        input  valid, setpoint_fresh, clear_request, estop_request, speed_request,
               turn_request, setpoint_rx_time, now_time, ir_mask, bus_off, estop_line,
        output ready
    );
endinterface

interface dfs_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        mode;
    logic [dfs_pkg::FAULT_W-1:0]       fault_flags;
    logic                              drive_enabled;
    logic signed [dfs_pkg::CMD_W-1:0]  speed_command;
    logic signed [dfs_pkg::CMD_W-1:0]  turn_command;
    logic                              stop_event;
    logic [1:0]                        stop_code;
    logic [dfs_pkg::AGE_MS_W-1:0]      link_age_ms;
    logic                              watchdog_miss;

    modport source (
        output valid, mode, fault_flags, drive_enabled, speed_command, turn_command,
               stop_event, stop_code, link_age_ms, watchdog_miss,
        input  ready
    );
    modport sink (
        input  valid, mode, fault_flags, drive_enabled, speed_command, turn_command,
               stop_event, stop_code, link_age_ms, watchdog_miss,
        output ready
    );
endinterface

interface dfs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dfs_pkg::CFG_INDEX_W-1:0]   index;
    logic [dfs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/dfs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dfs_cfg_regs
// Configuration register file; keeps the watchdog limit pre-scaled to us.
// ----------------------------------------------------------------------------
module dfs_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    dfs_cfg_if.sink       cfg,
    output dfs_pkg::cfg_t cfg_regs
);
    import dfs_pkg::*;

    logic [SPEED_LIM_W-1:0] max_speed_reg;
    logic [TURN_LIM_W-1:0]  max_turn_rate_reg;
    logic [STEP_W-1:0]      decel_step_reg;
    logic [LIMIT_US_W-1:0]  limit_us_reg;
    logic [BAND_W-1:0]      zero_band_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg     <= MAX_SPEED_RST;
            max_turn_rate_reg <= MAX_TURN_RST;
            decel_step_reg    <= DECEL_STEP_RST;
            limit_us_reg      <= LIMIT_US_RST;
            zero_band_reg     <= ZERO_BAND_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_MAX_SPEED:     max_speed_reg     <= cfg.data[SPEED_LIM_W-1:0];
                CFG_MAX_TURN_RATE: max_turn_rate_reg <= cfg.data[TURN_LIM_W-1:0];
                CFG_DECEL_STEP:    decel_step_reg    <= cfg.data[STEP_W-1:0];
                // watchdog limit held in microseconds
                CFG_WATCHDOG_MS:   limit_us_reg      <=
                    LIMIT_US_W'(32'(cfg.data[WDOG_W-1:0]) * US_PER_MS);
                CFG_ZERO_BAND:     zero_band_reg     <= cfg.data[BAND_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cfg_regs.max_speed     = max_speed_reg;
        cfg_regs.max_turn_rate = max_turn_rate_reg;
        cfg_regs.decel_step    = decel_step_reg;
        cfg_regs.limit_us      = limit_us_reg;
        cfg_regs.zero_band     = zero_band_reg;
    end

endmodule

// ----- rtl/dfs_core.sv -----
// ----------------------------------------------------------------------------
// dfs_core
// Supervisor state and the per-tick update: setpoint clamp, IR block,
// watchdog, mode changes and speed/turn slew.
// ----------------------------------------------------------------------------
module dfs_core #(
    parameter int IR_BITS   = dfs_pkg::IR_BITS_DEF,
    parameter int TIME_BITS = dfs_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dfs_pkg::cfg_t                    cfg_regs,
    input  logic                             step_en,
    input  logic                             setpoint_fresh,
    input  logic                             clear_request,
    input  logic                             estop_request,
    input  logic signed [dfs_pkg::REQ_W-1:0] speed_request,
    input  logic signed [dfs_pkg::REQ_W-1:0] turn_request,
    input  logic [TIME_BITS-1:0]             setpoint_rx_time,
    input  logic [TIME_BITS-1:0]             now_time,
    input  logic [IR_BITS-1:0]               ir_mask,
    input  logic                             bus_off,
    input  logic                             estop_line,
    output dfs_pkg::result_t                 res,
    output logic [TIME_BITS-1:0]             age_us
);
    import dfs_pkg::*;

    localparam logic [IR_BITS-1:0] IR_CENTER_MASK = IR_BITS'(2);

    typedef struct packed {
        logic                    hit;
        logic signed [REQ_W-1:0] value;
    } clamp_t;

    function automatic clamp_t clamp_req(
        input logic signed [REQ_W-1:0] v,
        input logic [TURN_LIM_W-1:0]   lim
    );
        logic signed [REQ_W:0] v_ext;
        logic signed [REQ_W:0] l_ext;
        clamp_t                r;
        v_ext   = {v[REQ_W-1], v};
        l_ext   = $signed((REQ_W+1)'(lim));
        r.hit   = 1'b1;
        r.value = v;
        if (v_ext > l_ext)
        begin
            r.value = l_ext[REQ_W-1:0];
        end
        else if (v_ext < -l_ext)
        begin
            r.value = REQ_W'(-l_ext);
        end
        else
        begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

    mode_t                   mode_reg, mode_next;
    logic [FAULT_W-1:0]      fault_reg, fault_next;
    logic                    bridge_reg, bridge_next;
    logic signed [CMD_W-1:0] speed_ramp_reg, speed_ramp_next;
    logic signed [CMD_W-1:0] turn_ramp_reg, turn_ramp_next;
    logic signed [REQ_W-1:0] speed_tgt_reg, speed_tgt_next;
    logic signed [REQ_W-1:0] turn_tgt_reg, turn_tgt_next;
    logic [TIME_BITS-1:0]    last_rx_reg, last_rx_next;

    clamp_t                  clamp_v, clamp_w;
    logic [TIME_BITS-1:0]    limit_ext;
    logic [TIME_BITS-1:0]    age;
    logic signed [CMD_W-1:0] tgt_v, tgt_w;
    logic [SLEW_STEP_W-1:0]  step_v, step_w;
    logic                    miss, stop_ev;
    stop_code_t              code;

    always_comb
    begin
        mode_next       = mode_reg;
        fault_next      = fault_reg;
        bridge_next     = bridge_reg;
        speed_ramp_next = speed_ramp_reg;
        turn_ramp_next  = turn_ramp_reg;
        speed_tgt_next  = speed_tgt_reg;
        turn_tgt_next   = turn_tgt_reg;
        last_rx_next    = last_rx_reg;
        miss            = 1'b0;
        stop_ev         = 1'b0;
        code            = STOP_LINK;
        clamp_v = clamp_req(speed_request, TURN_LIM_W'(cfg_regs.max_speed));
        clamp_w = clamp_req(turn_request, cfg_regs.max_turn_rate);
        limit_ext = TIME_BITS'(cfg_regs.limit_us);

        if (setpoint_fresh)
        begin
            last_rx_next = setpoint_rx_time;
            if (clear_request && mode_next == MODE_SAFE && ir_mask == '0 && !bus_off)
            begin
                fault_next      = '0;
                speed_ramp_next = '0;
                turn_ramp_next  = '0;
                mode_next       = MODE_IDLE;
            end
            if (estop_request)
            begin
                fault_next[FLT_ESTOP] = 1'b1;
                speed_tgt_next        = '0;
                turn_tgt_next         = '0;
            end
            else
            begin
                fault_next[FLT_ESTOP] = 1'b0;
                speed_tgt_next        = clamp_v.value;
                turn_tgt_next         = clamp_w.value;
                fault_next[FLT_RANGE] = clamp_v.hit | clamp_w.hit;
            end
            fault_next[FLT_LINK] = 1'b0;
            if (mode_next == MODE_IDLE || mode_next == MODE_DEG)
            begin
                mode_next   = MODE_RUN;
                bridge_next = 1'b1;
            end
        end

        // obstacle: no forward motion, center sensor degrades a running drive
        if (ir_mask != '0)
        begin
            fault_next[FLT_IR] = 1'b1;
            if (speed_tgt_next > 0)
            begin
                speed_tgt_next = '0;
            end
            if ((ir_mask & IR_CENTER_MASK) != '0 && mode_next == MODE_RUN)
            begin
                mode_next = MODE_DEG;
            end
        end
        else
        begin
            fault_next[FLT_IR] = 1'b0;
        end

        // zero stamp means never received
        if (last_rx_next == '0)
        begin
            age = limit_ext + TIME_BITS'(1);
        end
        else if (now_time >= last_rx_next)
        begin
            age = now_time - last_rx_next;
        end
        else
        begin
            age = '0;
        end

        if ((mode_next == MODE_RUN || mode_next == MODE_DEG) && age > limit_ext)
        begin
            miss                 = (mode_next == MODE_RUN);
            fault_next[FLT_LINK] = 1'b1;
            mode_next            = MODE_DEG;
        end

        if (bus_off)
        begin
            fault_next[FLT_BUSOFF] = 1'b1;
            if (mode_next == MODE_RUN)
            begin
                mode_next = MODE_DEG;
            end
        end
        if (estop_line)
        begin
            fault_next[FLT_ESTOP] = 1'b1;
            if (mode_next == MODE_RUN)
            begin
                mode_next = MODE_DEG;
            end
        end

        tgt_v = '0;
        tgt_w = '0;
        case (mode_next)
            MODE_RUN:
            begin
                tgt_v  = {speed_tgt_next, {FRAC_BITS{1'b0}}};
                tgt_w  = {turn_tgt_next, {FRAC_BITS{1'b0}}};
                step_v = SLEW_STEP_W'({cfg_regs.decel_step, 1'b0});
            end
            MODE_DEG:
            begin
                step_v = SLEW_STEP_W'(cfg_regs.decel_step);
            end
            default:
            begin
                step_v = SLEW_STEP_W'({cfg_regs.decel_step, 2'b00});
            end
        endcase
        // turn slews four times faster
        step_w = {step_v[SLEW_STEP_W-3:0], 2'b00};

        speed_ramp_next = slew(speed_ramp_next, tgt_v, step_v, cfg_regs.zero_band);
        turn_ramp_next  = slew(turn_ramp_next, tgt_w, step_w, cfg_regs.zero_band);

        // degraded ramp has reached zero: latch safe stop
        if (mode_next == MODE_DEG &&
            mag(speed_ramp_next) < (CMD_W+1)'(cfg_regs.zero_band) &&
            mag(turn_ramp_next) < (CMD_W+1)'(cfg_regs.zero_band))
        begin
            speed_ramp_next = '0;
            turn_ramp_next  = '0;
            if (fault_next[FLT_LINK])
            begin
                code = STOP_LINK;
            end
            else if (fault_next[FLT_IR])
            begin
                code = STOP_IR;
            end
            else
            begin
                code = STOP_BUSOFF;
            end
            mode_next   = MODE_SAFE;
            bridge_next = 1'b0;
            stop_ev     = 1'b1;
        end

        res.mode          = mode_next;
        res.fault_flags   = fault_next;
        res.drive_enabled = bridge_next;
        res.speed_command = speed_ramp_next;
        res.turn_command  = turn_ramp_next;
        res.stop_event    = stop_ev;
        res.stop_code     = code;
        res.watchdog_miss = miss;
        age_us            = age;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            fault_reg      <= '0;
            bridge_reg     <= 1'b0;
            speed_ramp_reg <= '0;
            turn_ramp_reg  <= '0;
            speed_tgt_reg  <= '0;
            turn_tgt_reg   <= '0;
            last_rx_reg    <= '0;
        end
        else if (step_en)
        begin
            mode_reg       <= mode_next;
            fault_reg      <= fault_next;
            bridge_reg     <= bridge_next;
            speed_ramp_reg <= speed_ramp_next;
            turn_ramp_reg  <= turn_ramp_next;
            speed_tgt_reg  <= speed_tgt_next;
            turn_tgt_reg   <= turn_tgt_next;
            last_rx_reg    <= last_rx_next;
        end
    end

endmodule

// ----- rtl/dfs_age_div.sv -----
// ----------------------------------------------------------------------------
// dfs_age_div
// Link age from microseconds to saturated milliseconds: reciprocal
// multiply registered, then shift and saturate select.
// ----------------------------------------------------------------------------
module dfs_age_div #(
    parameter int TIME_BITS = dfs_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            load_en,
    input  logic [TIME_BITS-1:0]            age_us,
    output logic [dfs_pkg::AGE_MS_W-1:0]    age_ms
);
    import dfs_pkg::*;

    logic              sat_reg, sat_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // below the saturation point the age fits LIMIT_US_W bits
    always_comb
    begin
        sat_next  = (age_us >= TIME_BITS'(AGE_SAT_US));
        prod_next = PROD_W'(age_us[DIV_IN_HI:DIV_PRE_SHIFT]) * PROD_W'(DIV_MULT);
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            sat_reg  <= sat_next;
            prod_reg <= prod_next;
        end
    end

    assign age_ms = sat_reg ? {AGE_MS_W{1'b1}} : prod_reg[DIV_SHIFT +: AGE_MS_W];

endmodule

// ----- rtl/drive_failsafe_supervisor.sv -----
// ----------------------------------------------------------------------------
// drive_failsafe_supervisor
// Failsafe mode supervisor for a differential drive: one control tick in,
// one ramped command with mode, faults and stop report out.
// ----------------------------------------------------------------------------
// item_in carries one control tick (setpoint, flags, IR mask, bus-off and
// estop lines, timestamps); result_out carries one result item per tick.
// cfg writes the five limit registers by index; it is always ready and
// should only be written while no tick is in flight.
// Items pass an input register, the state update stage, the age multiply
// stage and the output register; one item is accepted per cycle while the
// receiver takes results. The supervisor state is updated as an item leaves
// the input register, which is what sets the one-item-per-cycle rate.
// Each stage holds its item while the next one is full, so a stalled
// receiver fills the pipeline stage by stage before item_in.ready drops;
// results are never dropped or repeated.
// Reset clears the mode to idle, all faults, ramps, targets and the last
// receive time, and loads the register defaults.
// ----------------------------------------------------------------------------
module drive_failsafe_supervisor #(
    parameter int IR_BITS   = dfs_pkg::IR_BITS_DEF,
    parameter int TIME_BITS = dfs_pkg::TIME_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dfs_in_if.sink     item_in,
    dfs_out_if.source  result_out,
    dfs_cfg_if.sink    cfg
);
    import dfs_pkg::*;

    cfg_t cfg_regs;

    // input register
    logic                    s0_valid_reg;
    logic                    fresh_reg, clear_reg, estop_req_reg;
    logic signed [REQ_W-1:0] speed_req_reg, turn_req_reg;
    logic [TIME_BITS-1:0]    rx_time_reg, now_time_reg;
    logic [IR_BITS-1:0]      ir_mask_reg;
    logic                    bus_off_reg, estop_line_reg;

    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    result_t                 s1_res_reg, s2_res_reg, s3_res_reg;
    logic [TIME_BITS-1:0]    s1_age_reg;
    logic [AGE_MS_W-1:0]     s3_age_ms_reg;

    logic                    ready0, ready1, ready2, ready3;
    result_t                 core_res;
    logic [TIME_BITS-1:0]    core_age;
    logic [AGE_MS_W-1:0]     div_age_ms;

    assign ready3 = !s3_valid_reg || result_out.ready;
    assign ready2 = !s2_valid_reg || ready3;
    assign ready1 = !s1_valid_reg || ready2;
    assign ready0 = !s0_valid_reg || ready1;

    assign item_in.ready = ready0;

    dfs_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    dfs_core #(
        .IR_BITS   (IR_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_regs         (cfg_regs),
        .step_en          (s0_valid_reg && ready1),
        .setpoint_fresh   (fresh_reg),
        .clear_request    (clear_reg),
        .estop_request    (estop_req_reg),
        .speed_request    (speed_req_reg),
        .turn_request     (turn_req_reg),
        .setpoint_rx_time (rx_time_reg),
        .now_time         (now_time_reg),
        .ir_mask          (ir_mask_reg),
        .bus_off          (bus_off_reg),
        .estop_line       (estop_line_reg),
        .res              (core_res),
        .age_us           (core_age)
    );

    dfs_age_div #(
        .TIME_BITS (TIME_BITS)
    ) u_age_div (
        .clk     (clk),
        .load_en (s1_valid_reg && ready2),
        .age_us  (s1_age_reg),
        .age_ms  (div_age_ms)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                s0_valid_reg <= item_in.valid;
            end
            if (ready1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready0 && item_in.valid)
        begin
            fresh_reg      <= item_in.setpoint_fresh;
            clear_reg      <= item_in.clear_request;
            estop_req_reg  <= item_in.estop_request;
            speed_req_reg  <= item_in.speed_request;
            turn_req_reg   <= item_in.turn_request;
            rx_time_reg    <= item_in.setpoint_rx_time;
            now_time_reg   <= item_in.now_time;
            ir_mask_reg    <= item_in.ir_mask;
            bus_off_reg    <= item_in.bus_off;
            estop_line_reg <= item_in.estop_line;
        end
        if (ready1 && s0_valid_reg)
        begin
            s1_res_reg <= core_res;
            s1_age_reg <= core_age;
        end
        if (ready2 && s1_valid_reg)
        begin
            s2_res_reg <= s1_res_reg;
        end
        if (ready3 && s2_valid_reg)
        begin
            s3_res_reg    <= s2_res_reg;
            s3_age_ms_reg <= div_age_ms;
        end
    end

    assign result_out.valid         = s3_valid_reg;
    assign result_out.mode          = s3_res_reg.mode;
    assign result_out.fault_flags   = s3_res_reg.fault_flags;
    assign result_out.drive_enabled = s3_res_reg.drive_enabled;
    assign result_out.speed_command = s3_res_reg.speed_command;
    assign result_out.turn_command  = s3_res_reg.turn_command;
    assign result_out.stop_event    = s3_res_reg.stop_event;
    assign result_out.stop_code     = s3_res_reg.stop_code;
    assign result_out.link_age_ms   = s3_age_ms_reg;
    assign result_out.watchdog_miss = s3_res_reg.watchdog_miss;

endmodule

// ----- tb/tb_drive_failsafe_supervisor.sv -----
// ----------------------------------------------------------------------------
// tb_drive_failsafe_supervisor
// Self-checking bench for the drive failsafe supervisor. A class-based
// checker models the mode machine, fault flags, watchdog and slew ramps and
// queues one expected command per accepted tick. Stimulus starts with
// directed ticks and then runs random driving episodes (drive, silence,
// obstacle, bus-off, estop, recovery, noise) under several register
// settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_drive_failsafe_supervisor;

    import dfs_pkg::*;

    localparam int LATENCY       = 3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_SET = 340;
    localparam int IR_CENTER_BIT = 1;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic                    fresh;
        logic                    clear_req;
        logic                    estop_req;
        logic signed [REQ_W-1:0] speed_req;
        logic signed [REQ_W-1:0] turn_req;
        logic [47:0]             rx_time;
        logic [47:0]             now_us;
        logic [2:0]              ir;
        logic                    bus_off;
        logic                    estop_line;
    } tick_t;

    typedef struct {
        mode_t                   mode;
        logic [FAULT_W-1:0]      faults;
        logic                    enabled;
        logic signed [CMD_W-1:0] speed_cmd;
        logic signed [CMD_W-1:0] turn_cmd;
        logic                    stop_event;
        stop_code_t              stop_code;
        logic [AGE_MS_W-1:0]     age_ms;
        logic                    wd_miss;
    } cmd_t;

    typedef enum {
        EP_DRIVE,
        EP_SILENT,
        EP_OBSTACLE,
        EP_BUSOFF,
        EP_ESTOP,
        EP_RECOVER,
        EP_NOISE
    } episode_t;

    class failsafe_checker;
        // registers
        logic [SPEED_LIM_W-1:0] lim_speed;
        logic [TURN_LIM_W-1:0]  lim_turn;
        logic [STEP_W-1:0]      decel;
        logic [WDOG_W-1:0]      wd_ms;
        logic [BAND_W-1:0]      band;
        // supervisor state
        mode_t                  mode;
        logic [FAULT_W-1:0]     faults;
        logic                   bridge;
        int                     spd_ramp;
        int                     trn_ramp;
        int                     spd_tgt;
        int                     trn_tgt;
        logic [47:0]            last_rx;

        cmd_t                   expected_cmds[$];
        int                     errors;

        function new();
            lim_speed = MAX_SPEED_RST;
            lim_turn  = MAX_TURN_RST;
            decel     = DECEL_STEP_RST;
            wd_ms     = WATCHDOG_RST;
            band      = ZERO_BAND_RST;
            mode      = MODE_IDLE;
            faults    = '0;
            bridge    = 1'b0;
            spd_ramp  = 0;
            trn_ramp  = 0;
            spd_tgt   = 0;
            trn_tgt   = 0;
            last_rx   = '0;
            errors    = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_MAX_SPEED:     lim_speed = v[SPEED_LIM_W-1:0];
                CFG_MAX_TURN_RATE: lim_turn  = v[TURN_LIM_W-1:0];
                CFG_DECEL_STEP:    decel     = v;
                CFG_WATCHDOG_MS:   wd_ms     = v;
                CFG_ZERO_BAND:     band      = v;
                default: ;
            endcase
        endfunction

        function longint mag_of(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function int clamp_req(int v, int lim, output bit hit);
            hit = 1'b1;
            if (v > lim)
            begin
                return lim;
            end
            if (v < -lim)
            begin
                return -lim;
            end
            hit = 1'b0;
            return v;
        endfunction

        // step toward target by at most lim, then snap inside the zero band
        function int ramp_toward(int cur, int tgt, longint lim);
            longint d;
            longint nv;
            d = longint'(tgt) - longint'(cur);
            if (d > lim)
            begin
                d = lim;
            end
            else if (d < -lim)
            begin
                d = -lim;
            end
            nv = longint'(cur) + d;
            if (mag_of(nv) < longint'(band) && mag_of(longint'(tgt)) < longint'(band))
            begin
                nv = 0;
            end
            return int'(nv);
        endfunction

        function void take_tick(tick_t t);
            cmd_t                  e;
            bit                    hit_v;
            bit                    hit_w;
            longint unsigned       limit_us;
            longint unsigned       age_us;
            longint unsigned       age_ms;
            int                    tv;
            int                    tw;
            longint                slew_lim;
            e.stop_event = 1'b0;
            e.stop_code  = STOP_LINK;
            e.wd_miss    = 1'b0;

            if (t.fresh)
            begin
                last_rx = t.rx_time;
                if (t.clear_req && mode == MODE_SAFE && t.ir == '0 && !t.bus_off)
                begin
                    faults   = '0;
                    spd_ramp = 0;
                    trn_ramp = 0;
                    mode     = MODE_IDLE;
                end
                if (t.estop_req)
                begin
                    faults[FLT_ESTOP] = 1'b1;
                    spd_tgt = 0;
                    trn_tgt = 0;
                end
                else
                begin
                    faults[FLT_ESTOP] = 1'b0;
                    spd_tgt = clamp_req(int'(t.speed_req), int'(lim_speed), hit_v);
                    trn_tgt = clamp_req(int'(t.turn_req), int'(lim_turn), hit_w);
                    faults[FLT_RANGE] = hit_v | hit_w;
                end
                faults[FLT_LINK] = 1'b0;
                if (mode == MODE_IDLE || mode == MODE_DEG)
                begin
                    mode   = MODE_RUN;
                    bridge = 1'b1;
                end
            end

            // obstacle: no forward motion, center sensor degrades
            if (t.ir != '0)
            begin
                faults[FLT_IR] = 1'b1;
                if (spd_tgt > 0)
                begin
                    spd_tgt = 0;
                end
                if (t.ir[IR_CENTER_BIT] && mode == MODE_RUN)
                begin
                    mode = MODE_DEG;
                end
            end
            else
            begin
                faults[FLT_IR] = 1'b0;
            end

            limit_us = 64'(wd_ms) * 64'd1000;
            if (last_rx == '0)
            begin
                age_us = limit_us + 1;
            end
            else if (t.now_us >= last_rx)
            begin
                age_us = 64'(t.now_us) - 64'(last_rx);
            end
            else
            begin
                age_us = 0;
            end
            age_ms = age_us / 1000;
            if (age_ms > 65535)
            begin
                age_ms = 65535;
            end
            if ((mode == MODE_RUN || mode == MODE_DEG) && age_us > limit_us)
            begin
                if (mode == MODE_RUN)
                begin
                    e.wd_miss = 1'b1;
                end
                faults[FLT_LINK] = 1'b1;
                mode = MODE_DEG;
            end

            if (t.bus_off)
            begin
                faults[FLT_BUSOFF] = 1'b1;
                if (mode == MODE_RUN)
                begin
                    mode = MODE_DEG;
                end
            end
            if (t.estop_line)
            begin
                faults[FLT_ESTOP] = 1'b1;
                if (mode == MODE_RUN)
                begin
                    mode = MODE_DEG;
                end
            end

            tv = 0;
            tw = 0;
            if (mode == MODE_RUN)
            begin
                tv = spd_tgt * 256;
                tw = trn_tgt * 256;
                slew_lim = longint'(decel) * 2;
            end
            else if (mode == MODE_DEG)
            begin
                slew_lim = longint'(decel);
            end
            else
            begin
                slew_lim = longint'(decel) * 4;
            end
            spd_ramp = ramp_toward(spd_ramp, tv, slew_lim);
            trn_ramp = ramp_toward(trn_ramp, tw, slew_lim * 4);

            // degraded ramp has run out: latch safe stop
            if (mode == MODE_DEG && mag_of(longint'(spd_ramp)) < longint'(band) &&
                mag_of(longint'(trn_ramp)) < longint'(band))
            begin
                spd_ramp = 0;
                trn_ramp = 0;
                e.stop_code = faults[FLT_LINK] ? STOP_LINK :
                              faults[FLT_IR]   ? STOP_IR : STOP_BUSOFF;
                mode   = MODE_SAFE;
                bridge = 1'b0;
                e.stop_event = 1'b1;
            end

            e.mode      = mode;
            e.faults    = faults;
            e.enabled   = bridge;
            e.speed_cmd = CMD_W'(spd_ramp);
            e.turn_cmd  = CMD_W'(trn_ramp);
            e.age_ms    = AGE_MS_W'(age_ms);
            expected_cmds.push_back(e);
        endfunction

        function string cmd_text(cmd_t c);
            return $sformatf("mode=%0d flt=%b en=%0d spd=%0d trn=%0d stop=%0d/%0d age=%0d miss=%0d",
                             c.mode, c.faults, c.enabled, c.speed_cmd, c.turn_cmd,
                             c.stop_event, c.stop_code, c.age_ms, c.wd_miss);
        endfunction

        function void check_cmd(cmd_t got);
            cmd_t want;
            if (expected_cmds.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("result with nothing outstanding: %s", cmd_text(got));
                end
                return;
            end
            want = expected_cmds.pop_front();
            if (got.mode !== want.mode || got.faults !== want.faults ||
                got.enabled !== want.enabled || got.speed_cmd !== want.speed_cmd ||
                got.turn_cmd !== want.turn_cmd || got.stop_event !== want.stop_event ||
                got.stop_code !== want.stop_code || got.age_ms !== want.age_ms ||
                got.wd_miss !== want.wd_miss)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("mismatch at %0t\n  exp %s\n  got %s", $time,
                             cmd_text(want), cmd_text(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady = 1'b0;

    dfs_in_if #(.IR_BITS(3), .TIME_BITS(48)) tick_ch ();
    dfs_out_if                               cmd_ch ();
    dfs_cfg_if                               cfg_ch ();

    drive_failsafe_supervisor #(
        .IR_BITS   (3),
        .TIME_BITS (48)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (tick_ch),
        .result_out (cmd_ch),
        .cfg        (cfg_ch)
    );

    failsafe_checker sb = new();

    // random episode generator state
    logic [47:0] cur_us;
    episode_t    ep_kind;
    int          ep_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cmd_ch.ready <= steady || ($urandom_range(99) >= 10);
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            sb.write_reg(cfg_index_t'(cfg_ch.index), cfg_ch.data);
        end
    end

    always @(posedge clk)
    begin
        tick_t t;
        if (rst_n && tick_ch.valid && tick_ch.ready)
        begin
            t.fresh      = tick_ch.setpoint_fresh;
            t.clear_req  = tick_ch.clear_request;
            t.estop_req  = tick_ch.estop_request;
            t.speed_req  = tick_ch.speed_request;
            t.turn_req   = tick_ch.turn_request;
            t.rx_time    = tick_ch.setpoint_rx_time;
            t.now_us     = tick_ch.now_time;
            t.ir         = tick_ch.ir_mask;
            t.bus_off    = tick_ch.bus_off;
            t.estop_line = tick_ch.estop_line;
            sb.take_tick(t);
        end
    end

    always @(posedge clk)
    begin
        cmd_t got;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            got.mode       = mode_t'(cmd_ch.mode);
            got.faults     = cmd_ch.fault_flags;
            got.enabled    = cmd_ch.drive_enabled;
            got.speed_cmd  = cmd_ch.speed_command;
            got.turn_cmd   = cmd_ch.turn_command;
            got.stop_event = cmd_ch.stop_event;
            got.stop_code  = stop_code_t'(cmd_ch.stop_code);
            got.age_ms     = cmd_ch.link_age_ms;
            got.wd_miss    = cmd_ch.watchdog_miss;
            sb.check_cmd(got);
        end
    end

    function automatic tick_t tk(bit f, bit c, bit e, int spd, int trn,
                                 logic [47:0] rx, logic [47:0] now,
                                 logic [2:0] ir, bit bo, bit el);
        tick_t t;
        t.fresh      = f;
        t.clear_req  = c;
        t.estop_req  = e;
        t.speed_req  = REQ_W'(spd);
        t.turn_req   = REQ_W'(trn);
        t.rx_time    = rx;
        t.now_us     = now;
        t.ir         = ir;
        t.bus_off    = bo;
        t.estop_line = el;
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        tick_ch.valid            <= 1'b1;
        tick_ch.setpoint_fresh   <= t.fresh;
        tick_ch.clear_request    <= t.clear_req;
        tick_ch.estop_request    <= t.estop_req;
        tick_ch.speed_request    <= t.speed_req;
        tick_ch.turn_request     <= t.turn_req;
        tick_ch.setpoint_rx_time <= t.rx_time;
        tick_ch.now_time         <= t.now_us;
        tick_ch.ir_mask          <= t.ir;
        tick_ch.bus_off          <= t.bus_off;
        tick_ch.estop_line       <= t.estop_line;
        do
            @(posedge clk);
        while (!tick_ch.ready);
    endtask

    task automatic idle_gap();
        if (!steady && $urandom_range(99) < 10)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every outstanding command, then let the pipeline settle
    task automatic drain();
        while (sb.expected_cmds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic make_tick(output tick_t t);
        int r;
        int span_v;
        int span_w;
        if (ep_left == 0)
        begin
            r = $urandom_range(99);
            ep_kind = (r < 40) ? EP_DRIVE :
                      (r < 55) ? EP_SILENT :
                      (r < 65) ? EP_OBSTACLE :
                      (r < 73) ? EP_BUSOFF :
                      (r < 80) ? EP_ESTOP :
                      (r < 93) ? EP_RECOVER : EP_NOISE;
            ep_left = $urandom_range(3, 40);
        end
        ep_left--;

        span_v = int'(sb.lim_speed) + int'(sb.lim_speed) / 4 + 1;
        span_w = int'(sb.lim_turn) + int'(sb.lim_turn) / 4 + 1;
        cur_us = cur_us + 48'($urandom_range(900, 1100));
        t = tk(0, 0, 0, 0, 0, 0, cur_us, 0, 0, 0);
        r = $urandom_range(99);
        t.rx_time = (r < 3) ? 48'd0 :
                    (r < 8) ? cur_us + 48'($urandom_range(1, 3000)) :
                              cur_us - 48'($urandom_range(0, 2000));
        t.speed_req = ($urandom_range(99) < 15) ? REQ_W'($urandom) :
                      REQ_W'(int'($urandom_range(0, 2 * span_v)) - span_v);
        t.turn_req  = ($urandom_range(99) < 15) ? REQ_W'($urandom) :
                      REQ_W'(int'($urandom_range(0, 2 * span_w)) - span_w);

        case (ep_kind)
            EP_DRIVE:
            begin
                t.fresh     = ($urandom_range(99) < 85);
                t.clear_req = ($urandom_range(99) < 5);
                t.estop_req = ($urandom_range(99) < 3);
                t.ir        = ($urandom_range(99) < 5) ? 3'($urandom_range(1, 7)) : 3'd0;
                t.bus_off   = ($urandom_range(99) < 2);
            end
            EP_SILENT:
            begin
                t.fresh = ($urandom_range(99) < 4);
                // now and then a gap well past the watchdog limit
                if ($urandom_range(99) < 8)
                begin
                    cur_us = cur_us + 48'(64'(sb.wd_ms) * 64'd1000) +
                             48'($urandom_range(1, 3000));
                    t.now_us = cur_us;
                end
                t.ir = ($urandom_range(99) < 10) ? 3'($urandom_range(1, 7)) : 3'd0;
            end
            EP_OBSTACLE:
            begin
                t.fresh     = ($urandom_range(99) < 70);
                t.ir        = 3'($urandom_range(1, 7));
                t.speed_req = REQ_W'($urandom_range(0, span_v));
            end
            EP_BUSOFF:
            begin
                t.fresh     = ($urandom_range(99) < 50);
                t.bus_off   = ($urandom_range(99) < 90);
                t.clear_req = ($urandom_range(99) < 20);
            end
            EP_ESTOP:
            begin
                t.fresh      = ($urandom_range(99) < 50);
                t.estop_line = ($urandom_range(99) < 80);
                t.estop_req  = ($urandom_range(99) < 30);
            end
            EP_RECOVER:
            begin
                t.fresh     = 1'b1;
                t.clear_req = ($urandom_range(99) < 90);
                t.ir        = ($urandom_range(99) < 20) ? 3'($urandom_range(1, 7)) : 3'd0;
                t.bus_off   = ($urandom_range(99) < 10);
            end
            default:
            begin
                t.fresh      = 1'($urandom_range(1));
                t.clear_req  = 1'($urandom_range(1));
                t.estop_req  = 1'($urandom_range(1));
                t.ir         = 3'($urandom);
                t.bus_off    = 1'($urandom_range(1));
                t.estop_line = 1'($urandom_range(1));
                t.rx_time    = 48'({$urandom, $urandom});
                t.now_us     = 48'({$urandom, $urandom});
                t.speed_req  = REQ_W'($urandom);
                t.turn_req   = REQ_W'($urandom);
            end
        endcase
    endtask

    task automatic run_set(input int ms, input int mt, input int ds, input int wd,
                           input int zb, input bit no_gaps);
        tick_t t;
        drain();
        write_reg(CFG_MAX_SPEED, CFG_DATA_W'(ms));
        write_reg(CFG_MAX_TURN_RATE, CFG_DATA_W'(mt));
        write_reg(CFG_DECEL_STEP, CFG_DATA_W'(ds));
        write_reg(CFG_WATCHDOG_MS, CFG_DATA_W'(wd));
        write_reg(CFG_ZERO_BAND, CFG_DATA_W'(zb));
        steady  = no_gaps;
        cur_us  = 48'({$urandom, $urandom});
        ep_left = 0;
        repeat (ITEMS_PER_SET)
        begin
            make_tick(t);
            send_tick(t);
            idle_gap();
        end
        tick_ch.valid <= 1'b0;
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n                    = 1'b0;
        tick_ch.valid            = 1'b0;
        tick_ch.setpoint_fresh   = 1'b0;
        tick_ch.clear_request    = 1'b0;
        tick_ch.estop_request    = 1'b0;
        tick_ch.speed_request    = '0;
        tick_ch.turn_request     = '0;
        tick_ch.setpoint_rx_time = '0;
        tick_ch.now_time         = '0;
        tick_ch.ir_mask          = '0;
        tick_ch.bus_off          = 1'b0;
        tick_ch.estop_line       = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = '0;
        cfg_ch.data              = '0;
        cmd_ch.ready             = 1'b0;
        cur_us                   = '0;
        ep_kind                  = EP_DRIVE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks under the reset register values
        // idle, nothing ever received
        send_tick(tk(0, 0, 0, 0, 0, 0, 0, 3'b000, 0, 0));
        // setpoint stamped zero counts as never received: run, then watchdog
        send_tick(tk(1, 0, 0, 100, 50, 0, 1000, 3'b000, 0, 0));
        idle_gap();
        // requests at the field extremes, clamped with range fault
        send_tick(tk(1, 0, 0, 32767, -32768, 2000, 2000, 3'b000, 0, 0));
        send_tick(tk(1, 0, 0, -32768, 32767, 3000, 3000, 3'b000, 0, 0));
        // exactly at the limits, then one over
        send_tick(tk(1, 0, 0, -1000, -2000, 4000, 4000, 3'b000, 0, 0));
        send_tick(tk(1, 0, 0, 1001, 0, 5000, 5000, 3'b000, 0, 0));
        // side sensors block forward motion, center sensor degrades
        send_tick(tk(1, 0, 0, 500, 100, 6000, 6000, 3'b101, 0, 0));
        send_tick(tk(1, 0, 0, 500, 100, 7000, 7000, 3'b010, 0, 0));
        send_tick(tk(1, 0, 0, -300, 0, 8000, 8000, 3'b111, 0, 0));
        // tick stamped before the setpoint: age is zero
        send_tick(tk(1, 0, 0, 200, 0, 20000, 9000, 3'b000, 0, 0));
        // estop request, then cleared by a normal setpoint
        send_tick(tk(1, 0, 1, 200, 0, 10000, 10000, 3'b000, 0, 0));
        send_tick(tk(1, 0, 0, 200, 0, 11000, 11000, 3'b000, 0, 0));
        // estop line and bus-off lines
        send_tick(tk(0, 0, 0, 0, 0, 0, 12000, 3'b000, 0, 1));
        send_tick(tk(0, 0, 0, 0, 0, 0, 13000, 3'b000, 1, 0));
        // silence past the watchdog, ramp down to safe stop
        send_tick(tk(0, 0, 0, 0, 0, 0, 400000, 3'b000, 0, 0));
        send_tick(tk(0, 0, 0, 0, 0, 0, 401000, 3'b000, 0, 0));
        send_tick(tk(0, 0, 0, 0, 0, 0, 402000, 3'b000, 0, 0));
        send_tick(tk(0, 0, 0, 0, 0, 0, 403000, 3'b000, 0, 0));
        send_tick(tk(0, 0, 0, 0, 0, 0, 404000, 3'b000, 0, 0));
        // clear refused with an obstacle, refused with bus-off, then honored
        send_tick(tk(1, 1, 0, 0, 0, 500000, 500000, 3'b001, 0, 0));
        send_tick(tk(1, 1, 0, 0, 0, 501000, 501000, 3'b000, 1, 0));
        send_tick(tk(1, 1, 0, 0, 0, 502000, 502000, 3'b000, 0, 0));
        // time at its top value, then a saturating age
        send_tick(tk(1, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'b000, 0, 0));
        send_tick(tk(1, 0, 0, 0, 0, 1, 48'hFFFF_FFFF_FFFF, 3'b000, 0, 0));
        tick_ch.valid <= 1'b0;

        // upper extremes, lower extremes (no zero band), a gap-free set,
        // two random sets and the reset values written back
        run_set(4000, 8000, 65535, 65535, 65535, 1'b0);
        run_set(1, 1, 1, 1, 0, 1'b0);
        run_set(300, 600, 2048, 10, 512, 1'b1);
        run_set($urandom_range(1, 4000), $urandom_range(1, 8000), $urandom_range(64, 8192),
                $urandom_range(1, 30), $urandom_range(0, 4096), 1'b0);
        run_set($urandom_range(1, 4000), $urandom_range(1, 8000), $urandom_range(64, 8192),
                $urandom_range(1, 30), $urandom_range(0, 4096), 1'b0);
        run_set(1000, 2000, 256, 200, 256, 1'b0);

        drain();
        repeat (LATENCY * 4) @(posedge clk);
        if (sb.errors == 0 && sb.expected_cmds.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
